[design/crc32_packet_validator_assert.svh]
// assertion macros for the packet validator, included by the result stage
`ifndef CRC32_PACKET_VALIDATOR_ASSERT_SVH
`define CRC32_PACKET_VALIDATOR_ASSERT_SVH

// immediate-cycle check under reset
`define CPV_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// next-cycle implication under reset
`define CPV_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[design/cpv_pkg.sv]
// shared types, constants and crc functions of the packet validator
`timescale 1ns / 1ps

package cpv_pkg;

    localparam logic        MODE_TABLE  = 1'b0;
    localparam logic        MODE_PACKET = 1'b1;
    localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [8:0]  COUNT_MAX   = 9'd511;
    localparam logic [8:0]  IDX_ID_HI   = 9'd0;
    localparam logic [8:0]  IDX_ID_LO   = 9'd1;
    localparam logic [8:0]  IDX_CMD     = 9'd2;
    localparam logic [8:0]  IDX_LEN     = 9'd3;

    typedef logic [8:0] tbl_entry_t;

    typedef struct packed {
        logic       en;
        logic [7:0] cmd;
        tbl_entry_t entry;
    } tbl_wr_t;

    typedef struct packed {
        logic [15:0] pkt_id;
        logic [7:0]  cmd;
        logic [7:0]  len;
        logic [31:0] option;
        logic [31:0] rx_crc;
        logic [31:0] crc;
        logic [1:0]  pad;
        logic        size_match;
    } pkt_req_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {b, 24'd0};
        for (int k = 0; k < 8; k++)
        begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] crc_pad(input logic [31:0] c, input logic [1:0] pad);
        logic [31:0] z1;
        logic [31:0] z2;
        logic [31:0] z3;
        logic [31:0] r;
        z1 = crc_byte(c, 8'd0);
        z2 = crc_byte(z1, 8'd0);
        z3 = crc_byte(z2, 8'd0);
        case (pad)
            2'd0:    r = c;
            2'd1:    r = z1;
            2'd2:    r = z2;
            default: r = z3;
        endcase
        return r;
    endfunction

endpackage

[design/cpv_cmd_table.sv]
// command table memory with per-entry valid bits and registered lookup
`timescale 1ns / 1ps

module cpv_cmd_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cpv_pkg::tbl_wr_t    wr,
    input  logic                rd_en,
    input  logic [7:0]          rd_cmd,
    output cpv_pkg::tbl_entry_t rd_entry
);
    import cpv_pkg::*;

    localparam int          ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [8:0]  DEPTH_V = 9'(TABLE_DEPTH);

    tbl_entry_t             mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    tbl_entry_t             rd_data_reg;
    logic                   rd_hit_reg;
    logic                   wr_in_range;
    logic                   rd_in_range;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;

    assign wr_in_range = {1'b0, wr.cmd} < DEPTH_V;
    assign rd_in_range = {1'b0, rd_cmd} < DEPTH_V;
    assign wr_addr     = wr.cmd[ADDR_W-1:0];
    assign rd_addr     = rd_cmd[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr.en && wr_in_range)
        begin
            mem[wr_addr] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en && wr_in_range)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= rd_in_range && valid_reg[rd_addr];
            end
        end
    end

    // entries never written read as unknown with length zero
    assign rd_entry = rd_hit_reg ? rd_data_reg : '0;

endmodule

[design/cpv_parser.sv]
// per-byte packet parsing, running crc and table write decode
`timescale 1ns / 1ps

module cpv_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              mode,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic [7:0]        table_cmd,
    input  logic [7:0]        table_len,
    input  logic              table_known,
    output cpv_pkg::tbl_wr_t  wr,
    output logic              req_valid,
    output cpv_pkg::pkt_req_t req
);
    import cpv_pkg::*;

    logic [31:0] crc_acc_reg,    crc_acc_next;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic [15:0] id_reg,         id_next;
    logic [7:0]  cmd_reg,        cmd_next;
    logic [7:0]  len_reg,        len_next;
    logic [31:0] option_reg,     option_next;
    logic [31:0] rx_crc_reg,     rx_crc_next;
    logic [9:0]  lim;
    logic [9:0]  cov;
    logic        pkt_step;

    assign pkt_step = accept && (mode == MODE_PACKET);

    assign wr.en    = accept && (mode == MODE_TABLE);
    assign wr.cmd   = table_cmd;
    assign wr.entry = {table_known, table_len};

    always_comb
    begin
        id_next     = id_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        option_next = option_reg;
        rx_crc_next = rx_crc_reg;
        crc_acc_next = crc_acc_reg;
        case (byte_count_reg)
            IDX_ID_HI: id_next[15:8] = data_byte;
            IDX_ID_LO: id_next[7:0]  = data_byte;
            IDX_CMD:   cmd_next      = data_byte;
            IDX_LEN:   len_next      = data_byte;
            default:   ;
        endcase
        lim = 10'd4 + {2'd0, len_next};
        if ({1'b0, byte_count_reg} < lim)
        begin
            crc_acc_next = crc_byte(crc_acc_reg, data_byte);
            if (byte_count_reg inside {[9'd4:9'd7]})
            begin
                option_next[{byte_count_reg[1:0], 3'd0} +: 8] = data_byte;
            end
        end
        else if ({1'b0, byte_count_reg} < lim + 10'd4)
        begin
            rx_crc_next = {rx_crc_reg[23:0], data_byte};
        end
        byte_count_next = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                        : byte_count_reg + 9'd1;
        cov = ({1'b0, byte_count_next} < lim) ? {1'b0, byte_count_next} : lim;
    end

    assign req_valid      = pkt_step && last_byte;
    assign req.pkt_id     = id_next;
    assign req.cmd        = cmd_next;
    assign req.len        = len_next;
    assign req.option     = option_next;
    assign req.rx_crc     = rx_crc_next;
    assign req.crc        = crc_acc_next;
    assign req.pad        = 2'd0 - cov[1:0];
    assign req.size_match = {1'b0, byte_count_next} == (10'd8 + {2'd0, len_next});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_acc_reg    <= CRC_INIT;
            byte_count_reg <= '0;
            id_reg         <= '0;
            cmd_reg        <= '0;
            len_reg        <= '0;
            option_reg     <= '0;
            rx_crc_reg     <= '0;
        end
        else if (pkt_step)
        begin
            if (last_byte)
            begin
                crc_acc_reg    <= CRC_INIT;
                byte_count_reg <= '0;
                id_reg         <= '0;
                cmd_reg        <= '0;
                len_reg        <= '0;
                option_reg     <= '0;
                rx_crc_reg     <= '0;
            end
            else
            begin
                crc_acc_reg    <= crc_acc_next;
                byte_count_reg <= byte_count_next;
                id_reg         <= id_next;
                cmd_reg        <= cmd_next;
                len_reg        <= len_next;
                option_reg     <= option_next;
                rx_crc_reg     <= rx_crc_next;
            end
        end
    end

endmodule

[design/cpv_result.sv]
// crc padding, length and command checks, and the output register
`timescale 1ns / 1ps

module cpv_result (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  cpv_pkg::pkt_req_t   req,
    input  cpv_pkg::tbl_entry_t entry,
    output logic                stage_free,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         pkt_id,
    output logic [7:0]          cmd_out,
    output logic [7:0]          len_out,
    output logic [31:0]         option_bits,
    output logic                cmd_known,
    output logic                len_ok,
    output logic                crc_ok,
    output logic [31:0]         computed_crc
);
    import cpv_pkg::*;

    `include "crc32_packet_validator_assert.svh"

    pkt_req_t    s1_reg;
    logic        s1_valid_reg;
    logic        out_valid_reg;
    logic        out_load;
    logic [31:0] crc_final;
    logic        known;
    logic        lok;

    assign out_load   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign stage_free = !s1_valid_reg || out_load;

    assign crc_final = crc_pad(s1_reg.crc, s1_reg.pad);
    assign known     = entry[8];
    assign lok       = (s1_reg.len == 8'd0) || (s1_reg.size_match && entry[7:0] == s1_reg.len);

    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            s1_reg <= req;
        end
        if (out_load)
        begin
            pkt_id       <= s1_reg.pkt_id;
            cmd_out      <= known ? s1_reg.cmd : 8'd0;
            len_out      <= lok ? s1_reg.len : 8'd0;
            option_bits  <= (lok && s1_reg.len != 8'd0) ? s1_reg.option : 32'd0;
            cmd_known    <= known;
            len_ok       <= lok;
            crc_ok       <= s1_reg.rx_crc == crc_final;
            computed_crc <= crc_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_valid)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    `CPV_ASSERT_NEXT(a_stage_held, s1_valid_reg && !out_load, s1_valid_reg && $stable(s1_reg), "pending request lost in check stage")
    `CPV_ASSERT_NEXT(a_stage_moves, out_load, out_valid_reg, "check stage moved without output")
    `CPV_ASSERT(a_len_gate, !(out_valid_reg && !len_ok) || (len_out == 8'd0 && option_bits == 32'd0), "length fields not cleared on failed length")
    `CPV_ASSERT(a_cmd_gate, !(out_valid_reg && !cmd_known) || cmd_out == 8'd0, "command not cleared when unknown")

endmodule

[design/crc32_packet_validator.sv]
// top level of the crc-32 packet validator
// a request registers in the check stage, then in the output stage (out_valid)
// throughput: one request per cycle while in_ready is high; bytewise crc update
// table lookup uses a registered memory read issued with the last byte
// reset clears packet state and the table valid bits at once; no clearing pass
`timescale 1ns / 1ps

module crc32_packet_validator #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [7:0]  table_cmd,
    input  logic [7:0]  table_len,
    input  logic        table_known,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] pkt_id,
    output logic [7:0]  cmd_out,
    output logic [7:0]  len_out,
    output logic [31:0] option_bits,
    output logic        cmd_known,
    output logic        len_ok,
    output logic        crc_ok,
    output logic [31:0] computed_crc
);
    import cpv_pkg::*;

    tbl_wr_t    wr;
    pkt_req_t   req;
    logic       req_valid;
    tbl_entry_t entry;
    logic       stage_free;
    logic       accept;

    assign in_ready = stage_free;
    assign accept   = in_valid && in_ready;

    cpv_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .table_cmd   (table_cmd),
        .table_len   (table_len),
        .table_known (table_known),
        .wr          (wr),
        .req_valid   (req_valid),
        .req         (req)
    );

    cpv_cmd_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_en    (req_valid),
        .rd_cmd   (req.cmd),
        .rd_entry (entry)
    );

    cpv_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req          (req),
        .entry        (entry),
        .stage_free   (stage_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pkt_id       (pkt_id),
        .cmd_out      (cmd_out),
        .len_out      (len_out),
        .option_bits  (option_bits),
        .cmd_known    (cmd_known),
        .len_ok       (len_ok),
        .crc_ok       (crc_ok),
        .computed_crc (computed_crc)
    );

endmodule
